// ----- hdl/matrix3x3_inverse_defines.svh -----
// Assertion macros used by the matrix inverse merge module.
`ifndef MATRIX3X3_INVERSE_DEFINES_SVH
`define MATRIX3X3_INVERSE_DEFINES_SVH
`ifndef SYNTHESIS
`define MI_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("matrix inverse: assertion failed");
`define MI_ASSERT_NEVER(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("matrix inverse: forbidden condition seen");
`else
`define MI_ASSERT(lbl, clk, rst, prop)
`define MI_ASSERT_NEVER(lbl, clk, rst, cond)
`endif
`endif

// ----- hdl/mi_pkg.sv -----
// Shared types and constants for the 3x3 matrix inverse.
package mi_pkg;

  localparam int LANES     = 9;
  localparam int COF_W     = 32;   // cofactor magnitude
  localparam int DET_W     = 50;   // determinant magnitude
  localparam int QUO_W     = 26;   // quotient bits of 2n/d
  localparam int ELEM_W    = 24;
  localparam int THR_W     = 47;
  localparam logic [THR_W-1:0] THR_RESET = 47'd1;
  localparam logic [ELEM_W-1:0] ELEM_MAX = 24'h7FFFFF;
  localparam logic [ELEM_W-1:0] ELEM_MIN = 24'h800000;

  typedef struct packed {
    logic signed [15:0] a_r0c0;
    logic signed [15:0] a_r0c1;
    logic signed [15:0] a_r0c2;
    logic signed [15:0] a_r1c0;
    logic signed [15:0] a_r1c1;
    logic signed [15:0] a_r1c2;
    logic signed [15:0] a_r2c0;
    logic signed [15:0] a_r2c1;
    logic signed [15:0] a_r2c2;
  } in_t;

  typedef struct packed {
    logic signed [23:0] b_r0c0;
    logic signed [23:0] b_r0c1;
    logic signed [23:0] b_r0c2;
    logic signed [23:0] b_r1c0;
    logic signed [23:0] b_r1c1;
    logic signed [23:0] b_r1c2;
    logic signed [23:0] b_r2c0;
    logic signed [23:0] b_r2c1;
    logic signed [23:0] b_r2c2;
    logic               singular;
    logic               clipped;
  } out_t;

  typedef struct packed {
    logic             valid;
    logic             sing;
    logic             neg;
    logic [COF_W-1:0] cof_mag;
    logic [DET_W-1:0] det_mag;
  } lane_in_t;

  typedef struct packed {
    logic              valid;
    logic              sing;
    logic              clip;
    logic [ELEM_W-1:0] elem;
  } lane_out_t;

endpackage

// ----- hdl/matrix3x3_inverse.sv -----
// Top level of the 3x3 matrix inverse by the adjugate.
//
//  channel   handshake       payload
//  input     start / busy    a     (mi_pkg::in_t)
//  result    done            b     (mi_pkg::out_t)
//  config    min_det_we      min_det_wdata (47 bits)
//
// One matrix may start every cycle; busy is high only during reset.
// Pipeline: input register, five cofactor/determinant stages,
// a 27-step pipelined restoring divider in each of nine lanes, a rounding
// stage and the merge register. The divider, one quotient bit per stage,
// sets the depth. Reset clears all valid bits and sets the threshold to 1.
// The receiver cannot stall: each result is shown for one cycle with done.
module matrix3x3_inverse (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  mi_pkg::in_t              a,
  input  logic                     min_det_we,
  input  logic [mi_pkg::THR_W-1:0] min_det_wdata,
  output logic                     done,
  output mi_pkg::out_t             b
);

  logic [mi_pkg::THR_W-1:0] thr;
  logic                     in_vld;
  mi_pkg::in_t              a_reg;
  mi_pkg::lane_in_t         lane_in  [mi_pkg::LANES];
  mi_pkg::lane_out_t        lane_out [mi_pkg::LANES];

  assign busy = rst;

  // hold the threshold register
  always_ff @(posedge clk) begin
    if (rst)             thr <= mi_pkg::THR_RESET;
    else if (min_det_we) thr <= min_det_wdata;
  end

  // capture the accepted beat
  always_ff @(posedge clk) begin
    if (rst) in_vld <= 1'b0;
    else     in_vld <= start && !busy;
  end

  always_ff @(posedge clk) begin
    a_reg <= a;
  end

  mi_front u_front (
    .clk  (clk),
    .rst  (rst),
    .vld  (in_vld),
    .a    (a_reg),
    .thr  (thr),
    .lane (lane_in)
  );

  for (genvar i = 0; i < mi_pkg::LANES; i++) begin : g_lane
    mi_lane u_lane (
      .clk  (clk),
      .rst  (rst),
      .din  (lane_in[i]),
      .dout (lane_out[i])
    );
  end

  mi_merge u_merge (
    .clk  (clk),
    .rst  (rst),
    .lane (lane_out),
    .done (done),
    .b    (b)
  );

endmodule

// ----- hdl/mi_front.sv -----
// Cofactor and determinant pipeline feeding the divider lanes.
module mi_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          vld,
  input  mi_pkg::in_t                   a,
  input  logic [mi_pkg::THR_W-1:0]      thr,
  output mi_pkg::lane_in_t              lane [mi_pkg::LANES]
);

  logic [5:1] v;

  // stage 1: cofactor products
  logic signed [31:0] pa [9];
  logic signed [31:0] pb [9];
  logic signed [15:0] r0_1 [3];
  // stage 2: cofactors
  logic signed [32:0] cof2 [9];
  logic signed [15:0] r0_2 [3];
  // stage 3: determinant products
  logic signed [48:0] dp [3];
  logic signed [32:0] cof3 [9];
  // stage 4: determinant
  logic signed [50:0] det;
  logic signed [32:0] cof4 [9];
  // stage 5: magnitudes and singular test
  logic [mi_pkg::COF_W-1:0] cmag [9];
  logic                     cneg [9];
  logic [mi_pkg::DET_W-1:0] dmag;
  logic                     sing;

  logic [mi_pkg::DET_W-1:0] dmag_next;

  always_ff @(posedge clk) begin
    if (rst) v <= '0;
    else     v <= {v[4:1], vld};
  end

  always_ff @(posedge clk) begin
    pa[0] <= 32'(a.a_r1c1) * 32'(a.a_r2c2);  pb[0] <= 32'(a.a_r1c2) * 32'(a.a_r2c1);
    pa[1] <= 32'(a.a_r0c2) * 32'(a.a_r2c1);  pb[1] <= 32'(a.a_r0c1) * 32'(a.a_r2c2);
    pa[2] <= 32'(a.a_r0c1) * 32'(a.a_r1c2);  pb[2] <= 32'(a.a_r0c2) * 32'(a.a_r1c1);
    pa[3] <= 32'(a.a_r1c2) * 32'(a.a_r2c0);  pb[3] <= 32'(a.a_r1c0) * 32'(a.a_r2c2);
    pa[4] <= 32'(a.a_r0c0) * 32'(a.a_r2c2);  pb[4] <= 32'(a.a_r0c2) * 32'(a.a_r2c0);
    pa[5] <= 32'(a.a_r0c2) * 32'(a.a_r1c0);  pb[5] <= 32'(a.a_r0c0) * 32'(a.a_r1c2);
    pa[6] <= 32'(a.a_r1c0) * 32'(a.a_r2c1);  pb[6] <= 32'(a.a_r1c1) * 32'(a.a_r2c0);
    pa[7] <= 32'(a.a_r0c1) * 32'(a.a_r2c0);  pb[7] <= 32'(a.a_r0c0) * 32'(a.a_r2c1);
    pa[8] <= 32'(a.a_r0c0) * 32'(a.a_r1c1);  pb[8] <= 32'(a.a_r0c1) * 32'(a.a_r1c0);
    r0_1[0] <= a.a_r0c0;
    r0_1[1] <= a.a_r0c1;
    r0_1[2] <= a.a_r0c2;
  end

  // form cofactors, then expand along the first row
  always_ff @(posedge clk) begin
    for (int i = 0; i < 9; i++) begin
      cof2[i] <= 33'(pa[i]) - 33'(pb[i]);
      cof3[i] <= cof2[i];
      cof4[i] <= cof3[i];
    end
    r0_2  <= r0_1;
    dp[0] <= 49'(r0_2[0]) * 49'(cof2[0]);
    dp[1] <= 49'(r0_2[1]) * 49'(cof2[3]);
    dp[2] <= 49'(r0_2[2]) * 49'(cof2[6]);
    det   <= 51'(dp[0]) + 51'(dp[1]) + 51'(dp[2]);
  end

  always_comb begin
    dmag_next = det[50] ? mi_pkg::DET_W'(-det) : mi_pkg::DET_W'(det);
  end

  // take magnitudes and judge the determinant
  always_ff @(posedge clk) begin
    for (int i = 0; i < 9; i++) begin
      cmag[i] <= cof4[i][32] ? mi_pkg::COF_W'(-cof4[i]) : mi_pkg::COF_W'(cof4[i]);
      cneg[i] <= cof4[i][32] ^ det[50];
    end
    dmag <= dmag_next;
    sing <= (det == '0) || (dmag_next < mi_pkg::DET_W'(thr));
  end

  always_comb begin
    for (int i = 0; i < mi_pkg::LANES; i++) begin
      lane[i].valid   = v[5];
      lane[i].sing    = sing;
      lane[i].neg     = cneg[i];
      lane[i].cof_mag = cmag[i];
      lane[i].det_mag = dmag;
    end
  end

endmodule

// ----- hdl/mi_lane.sv -----
// One divider lane: rounded, saturated quotient of a cofactor by the determinant.
module mi_lane (
  input  logic              clk,
  input  logic              rst,
  input  mi_pkg::lane_in_t  din,
  output mi_pkg::lane_out_t dout
);

  localparam int QW  = mi_pkg::QUO_W;
  localparam int DW  = mi_pkg::DET_W;
  localparam int NW  = mi_pkg::COF_W + QW - 1;   // bits of 2n

  // per step: remainder, low dividend bits, quotient so far
  logic [QW:0]    v;
  logic [DW-1:0]  rem  [QW+1];
  logic [QW-1:0]  nlo  [QW+1];
  logic [QW-1:0]  q    [QW+1];
  logic [DW-1:0]  d    [QW+1];
  logic           ovf  [QW+1];
  logic           neg  [QW+1];
  logic           sing [QW+1];

  logic [NW-1:0]  num;

  assign num = {din.cof_mag, (QW - 1)'(0)};

  always_ff @(posedge clk) begin
    if (rst) v <= '0;
    else     v <= {v[QW-1:0], din.valid};
  end

  // load: quotient overflow check on the high part of 2n
  always_ff @(posedge clk) begin
    rem[0]  <= DW'(num[NW-1:QW]);
    nlo[0]  <= num[QW-1:0];
    q[0]    <= '0;
    d[0]    <= din.det_mag;
    ovf[0]  <= DW'(num[NW-1:QW]) >= din.det_mag;
    neg[0]  <= din.neg;
    sing[0] <= din.sing;
  end

  // one quotient bit per step
  for (genvar s = 0; s < QW; s++) begin : g_step
    logic [DW:0] trial;
    logic        take;
    assign trial = {rem[s], nlo[s][QW-1-s]};
    assign take  = trial >= {1'b0, d[s]};
    always_ff @(posedge clk) begin
      rem[s+1]  <= take ? DW'(trial - {1'b0, d[s]}) : DW'(trial);
      nlo[s+1]  <= nlo[s];
      q[s+1]    <= {q[s][QW-2:0], take};
      d[s+1]    <= d[s];
      ovf[s+1]  <= ovf[s];
      neg[s+1]  <= neg[s];
      sing[s+1] <= sing[s];
    end
  end

  // round half away from zero, then saturate
  logic [QW:0]   qsum;
  logic [QW-1:0] qr;
  logic          sat_pos;
  logic          sat_neg;

  assign qsum    = {1'b0, q[QW]} + (QW + 1)'(1);
  assign qr      = qsum[QW:1];
  assign sat_pos = ovf[QW] || (qr > QW'(mi_pkg::ELEM_MAX));
  assign sat_neg = ovf[QW] || (qr > QW'({1'b0, mi_pkg::ELEM_MIN}));

  always_ff @(posedge clk) begin
    if (rst) dout.valid <= 1'b0;
    else     dout.valid <= v[QW];
  end

  always_ff @(posedge clk) begin
    dout.sing <= sing[QW];
    if (neg[QW]) begin
      dout.clip <= sat_neg;
      dout.elem <= sat_neg ? mi_pkg::ELEM_MIN : mi_pkg::ELEM_W'(-qr);
    end else begin
      dout.clip <= sat_pos;
      dout.elem <= sat_pos ? mi_pkg::ELEM_MAX : mi_pkg::ELEM_W'(qr);
    end
  end

endmodule

// ----- hdl/mi_merge.sv -----
// Merge of the nine lanes into one result beat.
`include "matrix3x3_inverse_defines.svh"
module mi_merge (
  input  logic              clk,
  input  logic              rst,
  input  mi_pkg::lane_out_t lane [mi_pkg::LANES],
  output logic              done,
  output mi_pkg::out_t      b
);

  logic [mi_pkg::LANES-1:0] clips;
  logic [mi_pkg::ELEM_W-1:0] e [mi_pkg::LANES];
  logic sing;

  always_comb begin
    sing = lane[0].sing;
    for (int i = 0; i < mi_pkg::LANES; i++) begin
      clips[i] = lane[i].clip;
      e[i]     = sing ? '0 : lane[i].elem;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= lane[0].valid;
  end

  // zero the elements of a singular matrix, gather clip flags
  always_ff @(posedge clk) begin
    b.b_r0c0   <= e[0];
    b.b_r0c1   <= e[1];
    b.b_r0c2   <= e[2];
    b.b_r1c0   <= e[3];
    b.b_r1c1   <= e[4];
    b.b_r1c2   <= e[5];
    b.b_r2c0   <= e[6];
    b.b_r2c1   <= e[7];
    b.b_r2c2   <= e[8];
    b.singular <= sing;
    b.clipped  <= !sing && (|clips);
  end

  `MI_ASSERT_NEVER(a_sing_clip, clk, rst, done && b.singular && b.clipped)
  `MI_ASSERT(a_sing_zero, clk, rst, (done && b.singular) |-> (b.b_r0c0 == '0 && b.b_r2c2 == '0))
  `MI_ASSERT(a_no_spurious, clk, rst, !lane[0].valid |=> !done)
  `MI_ASSERT(a_lanes_aligned, clk, rst, lane[0].valid |-> (lane[8].valid && lane[4].valid))

endmodule

// ----- verif/tb.sv -----
// Self-checking testbench for the 3x3 matrix inverse block.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY = 35;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_ITEMS = 1450;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  mi_pkg::in_t a = '0;
  logic min_det_we = 1'b0;
  logic [mi_pkg::THR_W-1:0] min_det_wdata = '0;
  logic done;
  mi_pkg::out_t b;

  matrix3x3_inverse dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .a(a),
    .min_det_we(min_det_we), .min_det_wdata(min_det_wdata),
    .done(done), .b(b)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic [mi_pkg::THR_W-1:0] det_floor = mi_pkg::THR_RESET;
  mi_pkg::out_t inverse_queue[$];
  int errors = 0;
  int matrices_sent = 0;
  int inverses_seen = 0;
  int singular_seen = 0;
  int clipped_seen = 0;
  int idle_cycles = 0;
  int sender_gap_pct = 0;

  // Cofactor over Q8.24, det over Q12.36, rounded half away, saturated.
  function automatic logic signed [23:0] quotient_q12(longint cof, longint det,
                                                     ref bit clip);
    bit neg;
    longint unsigned n;
    longint unsigned d;
    longint unsigned q;
    neg = (cof < 0) != (det < 0);
    n = longint'(cof < 0 ? -cof : cof) << 24;
    d = longint'(det < 0 ? -det : det);
    q = (2 * n + d) / (2 * d);
    if (neg) begin
      if (q > 64'd8388608) begin
        clip = 1'b1;
        return mi_pkg::ELEM_MIN;
      end
      return 24'(-longint'(q));
    end
    if (q > 64'd8388607) begin
      clip = 1'b1;
      return mi_pkg::ELEM_MAX;
    end
    return 24'(q);
  endfunction

  function automatic mi_pkg::out_t predict_inverse(mi_pkg::in_t m);
    longint e[3][3];
    longint c[3][3];
    longint det;
    longint unsigned mag;
    bit clip;
    mi_pkg::out_t r;
    e[0][0] = m.a_r0c0; e[0][1] = m.a_r0c1; e[0][2] = m.a_r0c2;
    e[1][0] = m.a_r1c0; e[1][1] = m.a_r1c1; e[1][2] = m.a_r1c2;
    e[2][0] = m.a_r2c0; e[2][1] = m.a_r2c1; e[2][2] = m.a_r2c2;
    c[0][0] = e[1][1]*e[2][2] - e[1][2]*e[2][1];
    c[0][1] = e[0][2]*e[2][1] - e[0][1]*e[2][2];
    c[0][2] = e[0][1]*e[1][2] - e[0][2]*e[1][1];
    c[1][0] = e[1][2]*e[2][0] - e[1][0]*e[2][2];
    c[1][1] = e[0][0]*e[2][2] - e[0][2]*e[2][0];
    c[1][2] = e[0][2]*e[1][0] - e[0][0]*e[1][2];
    c[2][0] = e[1][0]*e[2][1] - e[1][1]*e[2][0];
    c[2][1] = e[0][1]*e[2][0] - e[0][0]*e[2][1];
    c[2][2] = e[0][0]*e[1][1] - e[0][1]*e[1][0];
    det = e[0][0]*c[0][0] + e[0][1]*c[1][0] + e[0][2]*c[2][0];
    mag = det < 0 ? -det : det;
    r = '0;
    clip = 1'b0;
    if (det == 0 || mag < 64'(det_floor)) begin
      r.singular = 1'b1;
      return r;
    end
    r.b_r0c0 = quotient_q12(c[0][0], det, clip);
    r.b_r0c1 = quotient_q12(c[0][1], det, clip);
    r.b_r0c2 = quotient_q12(c[0][2], det, clip);
    r.b_r1c0 = quotient_q12(c[1][0], det, clip);
    r.b_r1c1 = quotient_q12(c[1][1], det, clip);
    r.b_r1c2 = quotient_q12(c[1][2], det, clip);
    r.b_r2c0 = quotient_q12(c[2][0], det, clip);
    r.b_r2c1 = quotient_q12(c[2][1], det, clip);
    r.b_r2c2 = quotient_q12(c[2][2], det, clip);
    r.clipped = clip;
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    errors++;
    $display("MISMATCH result %0d %s: got %0d expected %0d",
             inverses_seen, what, got, want);
  endtask

  // Compare each done beat with the oldest expectation.
  always @(posedge clk) begin
    mi_pkg::out_t want;
    if (!rst && done) begin
      if (inverse_queue.size() == 0) begin
        report_mismatch("unexpected beat", 1, 0);
      end else begin
        want = inverse_queue.pop_front();
        if (b.b_r0c0 !== want.b_r0c0) report_mismatch("b_r0c0", b.b_r0c0, want.b_r0c0);
        if (b.b_r0c1 !== want.b_r0c1) report_mismatch("b_r0c1", b.b_r0c1, want.b_r0c1);
        if (b.b_r0c2 !== want.b_r0c2) report_mismatch("b_r0c2", b.b_r0c2, want.b_r0c2);
        if (b.b_r1c0 !== want.b_r1c0) report_mismatch("b_r1c0", b.b_r1c0, want.b_r1c0);
        if (b.b_r1c1 !== want.b_r1c1) report_mismatch("b_r1c1", b.b_r1c1, want.b_r1c1);
        if (b.b_r1c2 !== want.b_r1c2) report_mismatch("b_r1c2", b.b_r1c2, want.b_r1c2);
        if (b.b_r2c0 !== want.b_r2c0) report_mismatch("b_r2c0", b.b_r2c0, want.b_r2c0);
        if (b.b_r2c1 !== want.b_r2c1) report_mismatch("b_r2c1", b.b_r2c1, want.b_r2c1);
        if (b.b_r2c2 !== want.b_r2c2) report_mismatch("b_r2c2", b.b_r2c2, want.b_r2c2);
        if (b.singular !== want.singular)
          report_mismatch("singular", b.singular, want.singular);
        if (b.clipped !== want.clipped)
          report_mismatch("clipped", b.clipped, want.clipped);
        if (want.singular) singular_seen++;
        if (want.clipped) clipped_seen++;
      end
      inverses_seen++;
    end
  end

  // Watchdog: count cycles with no accepted beat on either side.
  always @(posedge clk) begin
    if (rst || done || (start && !busy)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog expired with %0d results pending", inverse_queue.size());
        $display("matrix3x3_inverse regression: fail");
        $finish;
      end
    end
  end

  // Drive one matrix beat and hold until accepted, with random gaps first.
  // start stays high after the beat; callers drop it before waiting.
  task automatic send_matrix(mi_pkg::in_t m, bit check_typed, mi_pkg::out_t typed);
    mi_pkg::out_t want;
    while ($urandom_range(99) < sender_gap_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    a <= m;
    do @(posedge clk); while (busy);
    want = predict_inverse(m);
    if (check_typed && want !== typed) begin
      report_mismatch($sformatf("typed row %0d b_r0c0", matrices_sent),
                      want.b_r0c0, typed.b_r0c0);
    end
    inverse_queue.insert(inverse_queue.size(), want);
    matrices_sent++;
  endtask

  // Drop start and wait for every expected result.
  task automatic drain_results();
    start <= 1'b0;
    while (inverse_queue.size() != 0) @(posedge clk);
  endtask

  // Let the pipeline empty, then write the threshold.
  task automatic set_det_floor(logic [mi_pkg::THR_W-1:0] value);
    drain_results();
    repeat (LATENCY + 4) @(posedge clk);
    min_det_we <= 1'b1;
    min_det_wdata <= value;
    @(posedge clk);
    min_det_we <= 1'b0;
    det_floor = value;
  endtask

  function automatic mi_pkg::in_t diag_matrix(logic signed [15:0] d0,
                                              logic signed [15:0] d1,
                                              logic signed [15:0] d2);
    mi_pkg::in_t m;
    m = '0;
    m.a_r0c0 = d0;
    m.a_r1c1 = d1;
    m.a_r2c2 = d2;
    return m;
  endfunction

  function automatic mi_pkg::out_t diag_inverse(logic signed [23:0] v, bit clip);
    mi_pkg::out_t r;
    r = '0;
    r.b_r0c0 = v;
    r.b_r1c1 = v;
    r.b_r2c2 = v;
    r.clipped = clip;
    return r;
  endfunction

  function automatic mi_pkg::in_t random_matrix(int mode);
    mi_pkg::in_t m;
    m = mi_pkg::in_t'({$urandom, $urandom, $urandom, $urandom, 16'($urandom)});
    case (mode)
      // small entries: large, often clipped inverses
      0: begin
        m.a_r0c0 = 16'($urandom_range(0, 511)) - 16'd256;
        m.a_r0c1 = 16'($urandom_range(0, 511)) - 16'd256;
        m.a_r0c2 = 16'($urandom_range(0, 511)) - 16'd256;
        m.a_r1c0 = 16'($urandom_range(0, 511)) - 16'd256;
        m.a_r1c1 = 16'($urandom_range(0, 511)) - 16'd256;
        m.a_r1c2 = 16'($urandom_range(0, 511)) - 16'd256;
        m.a_r2c0 = 16'($urandom_range(0, 511)) - 16'd256;
        m.a_r2c1 = 16'($urandom_range(0, 511)) - 16'd256;
        m.a_r2c2 = 16'($urandom_range(0, 511)) - 16'd256;
      end
      // near diag(1, -1, 1) with random perturbation
      1: begin
        m = mi_pkg::in_t'({$urandom, $urandom, $urandom, $urandom, 16'($urandom)})
            & {9{16'h03FF}};
        m.a_r0c0 = 16'h1000 + 16'($urandom_range(0, 2047));
        m.a_r1c1 = 16'hF000 - 16'($urandom_range(0, 2047));
        m.a_r2c2 = 16'h1000 + 16'($urandom_range(0, 2047));
      end
      // rank deficient: third row copies the first
      2: begin
        m.a_r2c0 = m.a_r0c0;
        m.a_r2c1 = m.a_r0c1;
        m.a_r2c2 = m.a_r0c2;
      end
      default: ;
    endcase
    return m;
  endfunction

  typedef struct {
    mi_pkg::in_t  m;
    bit           typed;
    mi_pkg::out_t want;
  } directed_row_t;

  directed_row_t rows[$];

  function automatic void add_row(mi_pkg::in_t m, bit typed, mi_pkg::out_t want);
    directed_row_t r;
    r.m = m;
    r.typed = typed;
    r.want = want;
    rows.insert(rows.size(), r);
  endfunction

  initial begin
    mi_pkg::out_t sing_result;
    logic [mi_pkg::THR_W-1:0] floors[5];
    int phase;
    int mode;

    sing_result = '0;
    sing_result.singular = 1'b1;
    // identity, negated identity, zero, extremes, all-ones, rank one
    add_row(diag_matrix(16'h1000, 16'h1000, 16'h1000), 1,
            diag_inverse(24'h001000, 0));
    add_row(diag_matrix(16'hF000, 16'hF000, 16'hF000), 1,
            diag_inverse(24'hFFF000, 0));
    add_row(mi_pkg::in_t'('0), 1, sing_result);
    add_row(mi_pkg::in_t'({9{16'h7FFF}}), 1, sing_result);
    add_row(mi_pkg::in_t'({9{16'h8000}}), 1, sing_result);
    add_row(mi_pkg::in_t'({9{16'hFFFF}}), 1, sing_result);
    add_row(diag_matrix(16'h0001, 16'h0001, 16'h0001), 1,
            diag_inverse(mi_pkg::ELEM_MAX, 1));
    add_row(diag_matrix(16'hFFFF, 16'hFFFF, 16'hFFFF), 1,
            diag_inverse(mi_pkg::ELEM_MIN, 1));
    add_row(diag_matrix(16'h7FFF, 16'h7FFF, 16'h7FFF), 0, '0);
    add_row(diag_matrix(16'h8000, 16'h8000, 16'h8000), 0, '0);
    add_row(diag_matrix(16'h8000, 16'h7FFF, 16'h8000), 0, '0);
    add_row(diag_matrix(16'h2000, 16'h0800, 16'hC000), 0, '0);
    add_row(mi_pkg::in_t'({16'h0000, 16'h1000, 16'h0000, 16'h1000, 16'h0000,
                           16'h0000, 16'h0000, 16'h0000, 16'h1000}), 0, '0);
    add_row(mi_pkg::in_t'({16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF,
                           16'h8000, 16'h7FFF, 16'h8000, 16'h8000}), 0, '0);
    add_row(mi_pkg::in_t'({16'h1234, 16'hEDCB, 16'h0F0F, 16'hA5A5, 16'h5A5A,
                           16'h0001, 16'h3000, 16'hC001, 16'h7001}), 0, '0);
    add_row(diag_matrix(16'h0003, 16'h1000, 16'h1000), 0, '0);

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[i]) send_matrix(rows[i].m, rows[i].typed, rows[i].want);

    floors[0] = '1;
    floors[1] = 47'd0;
    floors[2] = 47'h0000_1000_0000;
    floors[3] = 47'h0010_0000_0000;
    floors[4] = mi_pkg::THR_RESET;
    for (phase = 0; phase < 5; phase++) begin
      set_det_floor(floors[phase]);
      if (phase == 0) begin
        // a full-scale diagonal is still singular under the full threshold
        send_matrix(diag_matrix(16'h7FFF, 16'h7FFF, 16'h7FFF), 1, sing_result);
      end
      sender_gap_pct = phase < 2 ? 14 : (phase < 4 ? 83 : 0);
      for (int i = 0; i < RANDOM_ITEMS / 5; i++) begin
        mode = $urandom_range(0, 9);
        send_matrix(random_matrix(mode < 4 ? mode : 3), 0, '0);
        if (i == 150) begin
          // drain completely before resuming
          drain_results();
        end
      end
    end

    drain_results();
    repeat (LATENCY + 10) @(posedge clk);
    $display("sent %0d matrices over 5 threshold settings; %0d results checked",
             matrices_sent, inverses_seen);
    $display("%0d judged singular, %0d with clipped elements", singular_seen,
             clipped_seen);
    if (errors == 0 && inverse_queue.size() == 0) begin
      $display("matrix3x3_inverse regression: pass");
    end else begin
      $display("matrix3x3_inverse regression: fail");
    end
    $finish;
  end
endmodule

// ----- matrix3x3_inverse.f -----
+incdir+hdl
hdl/mi_pkg.sv
hdl/mi_front.sv
hdl/mi_lane.sv
hdl/mi_merge.sv
hdl/matrix3x3_inverse.sv
verif/tb.sv
